// ----- src/psnr_pkg.sv -----
// Package for the frame PSNR meter: field widths, register indexes and
// fixed-point constants shared by all modules but psnr_fifo. No dependencies.
`default_nettype none
package psnr_pkg;
   localparam int PIX_W     = 8;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 2;
   localparam int OUT_W     = 15;
   localparam int NUM_W     = 32;
   localparam int TOTAL_W   = 48;
   localparam int LOG_FRAC  = 28;
   localparam int MANT_W    = 31;
   localparam int TLC_W     = 26;
   localparam int SQ_W      = 2 * PIX_W;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [CSR_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
   localparam logic [CSR_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

   localparam logic [SQ_W-1:0]  PEAK_SQ     = 16'd65025;
   localparam logic [TLC_W-1:0] TEN_LOG10_2 = 26'd50504453;
   localparam logic [OUT_W-1:0] OUT_MAX     = 15'h7FFF;
endpackage
`default_nettype wire

// ----- src/frame_psnr_meter.sv -----
// Top level of the frame PSNR meter: front part, frame queue, back part and
// result queue. Depends on psnr_pkg, psnr_front, psnr_fifo and psnr_back.
//
// Pixel pairs enter on the request port (req_push/req_full) in raster order.
// The front part sums squared differences, one request per cycle when req_full
// is low. On the last sample of a frame it hands the sum and sample count to a
// two-entry queue, so pixels of the next frame keep flowing.
// The back part works on one frame at a time: two serial log2 passes (each a
// normalizing shift and 28 squarings), a multiply in states S_MUL0 and S_MUL1,
// a rounding state, an accumulate state, a bit-serial division of the 48-bit
// total by the frame count for the average, and an output state.
// A frame with no error skips the log passes, the multiply and the rounding.
// Frames faster than the back part fill the queue and req_full rises.
// Results wait in a two-entry queue (rsp_empty/rsp_pop); a stalled receiver
// stops the back part, then the front part, without loss.
// Frame size registers are written on the csr channel, which is always ready.
// Reset clears counters, queues, the error sum and the PSNR total; loads 1920x1080.
`default_nettype none
module frame_psnr_meter import psnr_pkg::*; #(
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data,
   output logic                      csr_ready,
   input  wire logic                 req_push,
   input  wire logic [PIX_W-1:0]     req_ref_pixel,
   input  wire logic [PIX_W-1:0]     req_test_pixel,
   output logic                      req_full,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output logic [OUT_W-1:0]          rsp_frame_psnr,
   output logic [NUM_W-1:0]          rsp_frame_number,
   output logic [OUT_W-1:0]          rsp_average_psnr
);
   localparam int CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int SSE_W = CNT_W + SQ_W;
   localparam int FQ_W  = SSE_W + CNT_W;
   localparam int RQ_W  = 2 * OUT_W + NUM_W;

   logic             fq_push, fq_full, fq_pop, fq_empty;
   logic [SSE_W-1:0] f_sse, b_sse;
   logic [CNT_W-1:0] f_cnt, b_cnt;
   logic             rq_push, rq_full;
   logic [OUT_W-1:0] b_psnr, b_avg;
   logic [NUM_W-1:0] b_num;
   logic [RQ_W-1:0]  rq_rdata;

   psnr_front #(.MAX_DIM(MAX_DIM), .CNT_W(CNT_W), .SSE_W(SSE_W)) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .csr_ready      (csr_ready),
      .req_push       (req_push),
      .req_ref_pixel  (req_ref_pixel),
      .req_test_pixel (req_test_pixel),
      .req_full       (req_full),
      .q_push         (fq_push),
      .q_full         (fq_full),
      .q_sse          (f_sse),
      .q_count        (f_cnt)
   );

   psnr_fifo #(.W(FQ_W), .DEPTH(2)) u_frame_q (
      .clock (clock),
      .reset (reset),
      .push  (fq_push),
      .wdata ({f_sse, f_cnt}),
      .full  (fq_full),
      .pop   (fq_pop),
      .rdata ({b_sse, b_cnt}),
      .empty (fq_empty)
   );

   psnr_back #(.CNT_W(CNT_W), .SSE_W(SSE_W), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (fq_empty),
      .q_pop     (fq_pop),
      .q_sse     (b_sse),
      .q_count   (b_cnt),
      .o_full    (rq_full),
      .o_push    (rq_push),
      .o_psnr    (b_psnr),
      .o_number  (b_num),
      .o_average (b_avg)
   );

   psnr_fifo #(.W(RQ_W), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .wdata ({b_psnr, b_num, b_avg}),
      .full  (rq_full),
      .pop   (rsp_pop),
      .rdata (rq_rdata),
      .empty (rsp_empty)
   );

   assign rsp_frame_psnr   = rq_rdata[RQ_W-1 -: OUT_W];
   assign rsp_frame_number = rq_rdata[OUT_W +: NUM_W];
   assign rsp_average_psnr = rq_rdata[OUT_W-1:0];
endmodule
`default_nettype wire

// ----- src/psnr_fifo.sv -----
// Small register queue with full and empty flags.
// Used between the front and back parts and in front of the result port.
`default_nettype none
module psnr_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] wdata,
   output logic              full,
   input  wire logic         pop,
   output logic [W-1:0]      rdata,
   output logic              empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

// ----- src/psnr_front.sv -----
// Front part: frame size registers, squared error accumulation and frame end
// detection. Depends on psnr_pkg.
`default_nettype none
module psnr_front import psnr_pkg::*; #(
   parameter int MAX_DIM = 4096,
   parameter int CNT_W   = 24,
   parameter int SSE_W   = 40
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data,
   output logic                      csr_ready,
   input  wire logic                 req_push,
   input  wire logic [PIX_W-1:0]     req_ref_pixel,
   input  wire logic [PIX_W-1:0]     req_test_pixel,
   output logic                      req_full,
   output logic                      q_push,
   input  wire logic                 q_full,
   output logic [SSE_W-1:0]          q_sse,
   output logic [CNT_W-1:0]          q_count
);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int TOT_W = 2 * DIM_W;

   logic [CSR_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [SSE_W-1:0] sse_ff, sse_in, sse_next;
   logic [CNT_W-1:0] pos_ff, pos_in, next_cnt;
   logic [DIM_W-1:0] cw, ch;
   logic [TOT_W-1:0] total;
   logic [PIX_W-1:0] diff;
   logic [SQ_W-1:0]  sq;
   logic             accept, last;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;
   assign cw        = clamp_dim(width_ff);
   assign ch        = clamp_dim(height_ff);
   assign total     = {{DIM_W{1'b0}}, cw} * {{DIM_W{1'b0}}, ch};
   assign diff      = (req_ref_pixel >= req_test_pixel) ? req_ref_pixel - req_test_pixel
                                                        : req_test_pixel - req_ref_pixel;
   assign sq        = {{PIX_W{1'b0}}, diff} * {{PIX_W{1'b0}}, diff};
   assign sse_next  = sse_ff + SSE_W'(sq);
   assign next_cnt  = pos_ff + CNT_W'(1);
   assign last      = (TOT_W'(next_cnt) >= total);
   assign accept    = req_push & ~q_full;
   assign req_full  = q_full;
   assign q_push    = accept & last;
   assign q_sse     = sse_next;
   assign q_count   = next_cnt;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      sse_in    = sse_ff;
      pos_in    = pos_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_in  = csr_data;
            REG_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
      if (accept) begin
         sse_in = last ? '0 : sse_next;
         pos_in = last ? '0 : next_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
         sse_ff    <= '0;
         pos_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         sse_ff    <= sse_in;
         pos_ff    <= pos_in;
      end
   end
endmodule
`default_nettype wire

// ----- src/psnr_log2.sv -----
// Iterative fixed-point log2: a one-bit-a-cycle normalizing shift, then one
// squaring of the mantissa per fraction bit. Depends on psnr_pkg.
`default_nettype none
module psnr_log2 import psnr_pkg::*; #(
   parameter int IN_W = 40
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [IN_W-1:0] x,
   output logic                 done,
   output logic [$clog2((IN_W > MANT_W) ? IN_W : MANT_W) + LOG_FRAC - 1:0] result
);
   localparam int NW   = (IN_W > MANT_W) ? IN_W : MANT_W;
   localparam int EW   = $clog2(NW);
   localparam int IT_W = $clog2(LOG_FRAC);
   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_NORM = 2'd1;
   localparam logic [1:0] L_SQR  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [NW-1:0]       x_ff, x_in;
   logic [EW-1:0]       e_ff, e_in;
   logic [MANT_W-1:0]   m_ff, m_in;
   logic [LOG_FRAC-1:0] f_ff, f_in;
   logic [IT_W-1:0]     it_ff, it_in;
   logic                done_ff, done_in;
   logic [2*MANT_W-1:0] prod;
   logic [MANT_W:0]     t;

   assign prod   = {{MANT_W{1'b0}}, m_ff} * {{MANT_W{1'b0}}, m_ff};
   assign t      = prod[2*MANT_W-1:MANT_W-1];
   assign done   = done_ff;
   assign result = {e_ff, f_ff};

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      f_in     = f_ff;
      it_in    = it_ff;
      done_in  = 1'b0;
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               x_in     = NW'(x);
               e_in     = EW'(NW - 1);
               state_in = L_NORM;
            end
         end
         L_NORM: begin
            if (x_ff[NW-1]) begin
               m_in     = x_ff[NW-1 -: MANT_W];
               f_in     = '0;
               it_in    = '0;
               state_in = L_SQR;
            end else begin
               x_in = {x_ff[NW-2:0], 1'b0};
               e_in = e_ff - EW'(1);
            end
         end
         L_SQR: begin
            if (t[MANT_W]) begin
               m_in = t[MANT_W:1];
               f_in = {f_ff[LOG_FRAC-2:0], 1'b1};
            end else begin
               m_in = t[MANT_W-1:0];
               f_in = {f_ff[LOG_FRAC-2:0], 1'b0};
            end
            it_in = it_ff + IT_W'(1);
            if (it_ff == IT_W'(LOG_FRAC - 1)) begin
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      e_ff  <= e_in;
      m_ff  <= m_in;
      f_ff  <= f_in;
      it_ff <= it_in;
   end
endmodule
`default_nettype wire

// ----- src/psnr_back.sv -----
// Back part: per-frame PSNR from the log unit, scaling, frame count, running
// total and bit-serial average division. Depends on psnr_pkg and psnr_log2.
`default_nettype none
module psnr_back import psnr_pkg::*; #(
   parameter int CNT_W     = 24,
   parameter int SSE_W     = 40,
   parameter int FRAC_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   output logic                  q_pop,
   input  wire logic [SSE_W-1:0] q_sse,
   input  wire logic [CNT_W-1:0] q_count,
   input  wire logic             o_full,
   output logic                  o_push,
   output logic [OUT_W-1:0]      o_psnr,
   output logic [NUM_W-1:0]      o_number,
   output logic [OUT_W-1:0]      o_average
);
   localparam int NW    = (SSE_W > MANT_W) ? SSE_W : MANT_W;
   localparam int DW    = $clog2(NW) + LOG_FRAC;
   localparam int LO_W  = (DW + 1) / 2;
   localparam int HI_W  = DW - LO_W;
   localparam int PW    = DW + TLC_W;
   localparam int SH    = 52 - FRAC_BITS;
   localparam int DC_W  = $clog2(TOTAL_W);
   localparam int ZV    = (100 << FRAC_BITS) > 32767 ? 32767 : (100 << FRAC_BITS);
   localparam logic [OUT_W-1:0] ZERO_PSNR = OUT_W'(ZV);
   localparam logic [PW:0]      HALF      = (PW + 1)'(1) << (SH - 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOGA = 4'd1;
   localparam logic [3:0] S_LOGB = 4'd2;
   localparam logic [3:0] S_MUL0 = 4'd3;
   localparam logic [3:0] S_MUL1 = 4'd4;
   localparam logic [3:0] S_RND  = 4'd5;
   localparam logic [3:0] S_ACC  = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0]         state_ff, state_in;
   logic [SSE_W-1:0]   sse_ff, sse_in;
   logic [DW-1:0]      a_ff, a_in, d_ff, d_in;
   logic [PW-1:0]      acc_ff, acc_in;
   logic [OUT_W-1:0]   psnr_ff, psnr_in;
   logic [NUM_W-1:0]   frames_ff, frames_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [NUM_W:0]     rem_ff, rem_in, sh_rem;
   logic [TOTAL_W-1:0] quo_ff, quo_in;
   logic [DC_W-1:0]    dcnt_ff, dcnt_in;
   logic               log_start, log_done;
   logic [SSE_W-1:0]   log_x;
   logic [DW-1:0]      log_res;
   logic [LO_W+TLC_W-1:0] lo_prod;
   logic [HI_W+TLC_W-1:0] hi_prod;
   logic [PW:0]        rnd, v;

   psnr_log2 #(.IN_W(SSE_W)) u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   assign lo_prod   = {{TLC_W{1'b0}}, d_ff[LO_W-1:0]} * {{LO_W{1'b0}}, TEN_LOG10_2};
   assign hi_prod   = {{TLC_W{1'b0}}, d_ff[DW-1:LO_W]} * {{HI_W{1'b0}}, TEN_LOG10_2};
   assign rnd       = {1'b0, acc_ff} + HALF;
   assign v         = rnd >> SH;
   assign sh_rem    = {rem_ff[NUM_W-1:0], quo_ff[TOTAL_W-1]};
   assign o_psnr    = psnr_ff;
   assign o_number  = frames_ff;
   assign o_average = quo_ff[OUT_W-1:0];

   always_comb begin
      state_in  = state_ff;
      sse_in    = sse_ff;
      a_in      = a_ff;
      d_in      = d_ff;
      acc_in    = acc_ff;
      psnr_in   = psnr_ff;
      frames_in = frames_ff;
      total_in  = total_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      q_pop     = 1'b0;
      o_push    = 1'b0;
      log_start = 1'b0;
      log_x     = {{CNT_W{1'b0}}, PEAK_SQ} * {{SQ_W{1'b0}}, q_count};
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               sse_in = q_sse;
               if (q_sse == '0) begin
                  psnr_in  = ZERO_PSNR;
                  state_in = S_ACC;
               end else begin
                  log_start = 1'b1;
                  state_in  = S_LOGA;
               end
            end
         end
         S_LOGA: begin
            if (log_done) begin
               a_in      = log_res;
               log_start = 1'b1;
               log_x     = sse_ff;
               state_in  = S_LOGB;
            end
         end
         S_LOGB: begin
            if (log_done) begin
               d_in     = (a_ff > log_res) ? a_ff - log_res : '0;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            acc_in   = PW'(lo_prod);
            state_in = S_MUL1;
         end
         S_MUL1: begin
            acc_in   = acc_ff + (PW'(hi_prod) << LO_W);
            state_in = S_RND;
         end
         S_RND: begin
            psnr_in  = (v > (PW + 1)'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            if (frames_ff != '1) begin
               frames_in = frames_ff + NUM_W'(1);
               total_in  = total_ff + TOTAL_W'(psnr_ff);
            end
            rem_in   = '0;
            quo_in   = total_in;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sh_rem >= {1'b0, frames_ff}) begin
               rem_in = sh_rem - {1'b0, frames_ff};
               quo_in = {quo_ff[TOTAL_W-2:0], 1'b1};
            end else begin
               rem_in = sh_rem;
               quo_in = {quo_ff[TOTAL_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + DC_W'(1);
            if (dcnt_ff == DC_W'(TOTAL_W - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!o_full) begin
               o_push   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         frames_ff <= '0;
         total_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         frames_ff <= frames_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      sse_ff  <= sse_in;
      a_ff    <= a_in;
      d_ff    <= d_in;
      acc_ff  <= acc_in;
      psnr_ff <= psnr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
   end
endmodule
`default_nettype wire

// ----- src/psnr_checker.sv -----
// Port-level checks for the frame PSNR meter and the bind that attaches them.
// Depends on psnr_pkg and frame_psnr_meter.
`default_nettype none
module psnr_checker import psnr_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 csr_ready,
   input wire logic                 req_full,
   input wire logic                 rsp_pop,
   input wire logic                 rsp_empty,
   input wire logic [OUT_W-1:0]     rsp_frame_psnr,
   input wire logic [NUM_W-1:0]     rsp_frame_number,
   input wire logic [OUT_W-1:0]     rsp_average_psnr
);
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("Queues are not empty after reset.");

   a_csr_ready: assert property (@(posedge clock) csr_ready)
      else $error("The register channel is not ready.");

   a_number_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_frame_number != '0)
      else $error("A result shows a frame count of zero.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("A waiting result vanished without being popped.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_frame_number) && $stable(rsp_frame_psnr)
      && $stable(rsp_average_psnr))
      else $error("A waiting result changed before being popped.");
endmodule

bind frame_psnr_meter psnr_checker u_psnr_checker (.*);
`default_nettype wire
